/* src/modbus_tcp_frame_parser_assert.svh */
// Assertion macros for the Modbus TCP frame parser.
`ifndef MODBUS_TCP_FRAME_PARSER_ASSERT_SVH
`define MODBUS_TCP_FRAME_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MBTCP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("modbus tcp frame parser: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MBTCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("modbus tcp frame parser: next-cycle check failed");

`endif

/* src/mbtcp_pkg.sv */
// Types and constants of the Modbus TCP frame parser.
package mbtcp_pkg;

    // Kind of result item.
    typedef enum logic [1:0] {
        EV_FRAME     = 2'd0,
        EV_PROTO_OFF = 2'd1,
        EV_BAD_LEN   = 2'd2
    } event_t;

    localparam int unsigned HDR_BYTES    = 7;
    localparam int unsigned PREFIX_BYTES = 6;
    localparam int unsigned MIN_LEN      = 2;
    localparam int unsigned MAX_LEN      = 255;
    localparam logic [7:0]  EXC_BIT      = 8'h80;
    localparam logic [7:0]  FC_MASK      = 8'h7f;

    localparam int unsigned POS_W = 9;

    // One result item.
    typedef struct packed {
        logic                report_unit_and_protocol;
        logic [7:0]          exception_code;
        logic                report_exception;
        logic                report_request;
        logic [7:0]          unit_id;
        logic [7:0]          function_code;
        logic [15:0]         transaction_id;
        logic                frame_direction;
        event_t              event_res;
    } result_t;

endpackage

/* src/modbus_tcp_frame_parser.sv */
// Modbus TCP frame parser: per-direction MBAP header tracking and frame reports.
//
// The parser takes one TCP payload byte per transfer, tagged with its direction and a
// segment-start flag, and follows each direction's position inside its Modbus TCP frame.
// A byte is held in the input register and is parsed on its way into the result register,
// so it sustains one byte per cycle while the input is not stalled. A report or event
// is registered as its byte leaves the input register, if the result register is free by
// then. A byte that has no result to deliver moves on even while a result waits. The input
// stalls only when the byte in the input register has a result and the result register
// holds one that is not being taken. A nonzero protocol id turns the parser off for both
// directions, and a length outside 2..255 stalls that direction, until the next reset.
module modbus_tcp_frame_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [0] direction, [1] segment_start
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] transaction_id, [23:16] function_code, [31:24] unit_id, [32] report_request,
    // [33] report_exception, [41:34] exception_code, [42] report_unit_and_protocol,
    // [47:43] zero
    output logic [47:0] m_tdata,
    output logic [2:0]  m_tuser    // [1:0] event_res, [2] frame_direction
);

    localparam int unsigned PW = mbtcp_pkg::POS_W;

    // Input register.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_dir_reg;
    logic       in_seg_reg;

    // Per-direction state.
    logic [PW-1:0] pos_reg     [2];
    logic [15:0]   tid_reg     [2];
    logic          proto_reg   [2];
    logic [15:0]   len_reg     [2];
    logic [7:0]    unit_reg    [2];
    logic [7:0]    func_reg    [2];
    logic [7:0]    exc_reg     [2];
    logic [1:0]    seg_cnt_reg [2];
    logic          stalled_reg [2];
    logic          parser_off_reg;

    // Result register.
    logic               out_valid_reg;
    mbtcp_pkg::result_t out_reg;

    logic [PW-1:0] pos_cur;
    logic [PW-1:0] pos_next;
    logic [15:0]   tid_next;
    logic          proto_next;
    logic [15:0]   len_next;
    logic [7:0]    unit_next;
    logic [7:0]    func_next;
    logic [7:0]    exc_next;
    logic [1:0]    seg_cnt_next;
    logic          active;
    logic          at_hdr;
    logic          proto_fail;
    logic          len_fail;
    logic          frame_end;
    logic          produces;
    logic          is_exc;
    logic          out_free;
    logic          take_in;
    logic          out_load;
    mbtcp_pkg::result_t res;

    assign out_free = !out_valid_reg || m_tready;
    assign take_in  = in_valid_reg && (out_free || !produces);
    assign out_load = take_in && produces;
    assign s_tready = !in_valid_reg || take_in;

    always_comb
    begin
        pos_cur    = pos_reg[in_dir_reg];
        tid_next   = tid_reg[in_dir_reg];
        proto_next = proto_reg[in_dir_reg];
        len_next   = len_reg[in_dir_reg];
        unit_next  = unit_reg[in_dir_reg];
        func_next  = func_reg[in_dir_reg];
        exc_next   = exc_reg[in_dir_reg];

        seg_cnt_next = seg_cnt_reg[in_dir_reg];
        if (in_seg_reg && seg_cnt_next != 2'd2)
        begin
            seg_cnt_next = seg_cnt_next + 2'd1;
        end

        case (pos_cur)
            9'd0:
            begin
                tid_next   = {in_byte_reg, 8'h00};
                proto_next = 1'b0;
            end
            9'd1: tid_next   = {tid_next[15:8], in_byte_reg};
            9'd2: proto_next = (in_byte_reg != 8'h00);
            9'd3: proto_next = proto_next || (in_byte_reg != 8'h00);
            9'd4: len_next   = {in_byte_reg, 8'h00};
            9'd5: len_next   = {len_next[15:8], in_byte_reg};
            9'd6: unit_next  = in_byte_reg;
            9'd7: func_next  = in_byte_reg;
            9'd8: exc_next   = in_byte_reg;
            default: ;
        endcase

        active     = !parser_off_reg && !stalled_reg[in_dir_reg];
        at_hdr     = (pos_cur == PW'(mbtcp_pkg::HDR_BYTES - 1));
        proto_fail = active && at_hdr && proto_next;
        len_fail   = active && at_hdr && !proto_next
                     && (len_next < 16'(mbtcp_pkg::MIN_LEN)
                         || len_next > 16'(mbtcp_pkg::MAX_LEN));
        frame_end  = active && !proto_fail && !len_fail
                     && (pos_cur >= PW'(mbtcp_pkg::HDR_BYTES - 1))
                     && ({8'b0, pos_cur} + 17'd1
                         == 17'(mbtcp_pkg::PREFIX_BYTES) + {1'b0, len_next});
        produces   = proto_fail || len_fail || frame_end;
        pos_next   = frame_end ? '0 : pos_cur + PW'(1);

        is_exc = in_dir_reg && ((func_next & mbtcp_pkg::EXC_BIT) != 8'h00);

        res = '0;
        res.frame_direction = in_dir_reg;
        if (proto_fail)
        begin
            res.event_res = mbtcp_pkg::EV_PROTO_OFF;
        end
        else if (len_fail)
        begin
            res.event_res = mbtcp_pkg::EV_BAD_LEN;
        end
        else
        begin
            res.event_res        = mbtcp_pkg::EV_FRAME;
            res.transaction_id   = tid_next;
            res.function_code    = is_exc ? (func_next & mbtcp_pkg::FC_MASK) : func_next;
            res.unit_id          = unit_next;
            res.report_request   = !in_dir_reg;
            res.report_exception = is_exc;
            res.exception_code   = (is_exc && len_next >= 16'd3) ? exc_next : 8'h00;
            res.report_unit_and_protocol = (seg_cnt_next == 2'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_dir_reg  <= s_tuser[0];
            in_seg_reg  <= s_tuser[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                pos_reg[i]     <= '0;
                tid_reg[i]     <= '0;
                proto_reg[i]   <= 1'b0;
                len_reg[i]     <= '0;
                unit_reg[i]    <= '0;
                func_reg[i]    <= '0;
                exc_reg[i]     <= '0;
                seg_cnt_reg[i] <= '0;
                stalled_reg[i] <= 1'b0;
            end
            parser_off_reg <= 1'b0;
        end
        else if (take_in)
        begin
            seg_cnt_reg[in_dir_reg] <= seg_cnt_next;
            if (active)
            begin
                tid_reg[in_dir_reg]   <= tid_next;
                proto_reg[in_dir_reg] <= proto_next;
                len_reg[in_dir_reg]   <= len_next;
                unit_reg[in_dir_reg]  <= unit_next;
                func_reg[in_dir_reg]  <= func_next;
                exc_reg[in_dir_reg]   <= exc_next;
                if (!proto_fail && !len_fail)
                begin
                    pos_reg[in_dir_reg] <= pos_next;
                end
            end
            if (len_fail)
            begin
                stalled_reg[in_dir_reg] <= 1'b1;
            end
            if (proto_fail)
            begin
                parser_off_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {out_reg.frame_direction, out_reg.event_res};
    assign m_tdata  = {5'b0, out_reg.report_unit_and_protocol, out_reg.exception_code,
                       out_reg.report_exception, out_reg.report_request, out_reg.unit_id,
                       out_reg.function_code, out_reg.transaction_id};

`include "modbus_tcp_frame_parser_assert.svh"

    // Once the parser is off, no byte may produce another result.
    `MBTCP_ASSERT_SAME(a_off_silent, clk, rst_n, parser_off_reg, !out_load)
    // A frame never runs past the longest legal frame.
    `MBTCP_ASSERT_SAME(a_pos_bound, clk, rst_n, 1'b1,
                       (pos_reg[0] <= 9'd260) && (pos_reg[1] <= 9'd260))
    // Turning the parser off always comes with its event on the output.
    `MBTCP_ASSERT_SAME(a_off_event, clk, rst_n, $rose(parser_off_reg),
                       m_tvalid && (m_tuser[1:0] == 2'(mbtcp_pkg::EV_PROTO_OFF)))

endmodule
